// File: sv/sma_pkg.sv
package sma_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed field widths
  localparam int WINDOW_BITS    = 7;
  localparam int FILL_BITS      = 7;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 7;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd8;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MEAN_KIND   = 1'd1;

  // command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // mean kinds
  localparam logic KIND_SIMPLE = 1'b0;

  typedef struct packed {
    logic accept;
    logic clear_win;
    logic rd_old;
    logic update;
    logic div_start;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/sma_chan_if.sv
interface sma_in_if #(
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface sma_out_if #(
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
);
  logic                           valid;
  logic                           ready;
  logic [SAMPLE_BITS-1:0]         average;
  logic                           window_full;
  logic [sma_pkg::FILL_BITS-1:0]  fill_count;

  modport source (output valid, output average, output window_full, output fill_count,
                  input ready);
  modport sink   (input valid, input average, input window_full, input fill_count,
                  output ready);
endinterface

// File: sv/moving_average_window.sv
// channel  | dir | beat contents                          | handshake
// in_if    | in  | cmd (append/clear), sample             | valid/ready
// out_if   | out | average, window_full, fill_count       | valid/ready
// cfg_*    | in  | cfg_index, cfg_data (window, mean kind)| cfg_we, no back-pressure
//
// an append runs through the restoring divider, which produces one quotient bit per
// cycle; a clear skips the divider and goes straight to the output register
// one beat is in flight at a time; in_if.ready is high only between beats
// the output register lets the next beat enter while a result waits on out_if
// synchronous active-low reset; the ring needs no clearing, only held samples are read
module moving_average_window #(
  parameter int MAX_WINDOW  = sma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sma_in_if.sink                             in_if,
  sma_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [sma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sma_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  sma_pkg::ctrl_cmd_t cmd;
  sma_pkg::ctrl_sts_t sts;
  logic               in_ready;

  // sequencer: accept, read oldest, update window, divide, emit; a clear empties the window and goes straight to emit
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_if.ready = in_ready;

  // ring, running sum, divider and output register
  sma_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_if.cmd),
    .in_sample       (in_if.sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_average     (out_if.average),
    .out_window_full (out_if.window_full),
    .out_fill_count  (out_if.fill_count)
  );

endmodule

// File: sv/sma_div.sv
module sma_div #(
  parameter int DIVIDEND_BITS = 22,
  parameter int DIVISOR_BITS  = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;
  logic [DIVISOR_BITS-1:0]  den_r;
  logic [STEP_BITS-1:0]     step_r, step_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = STEP_BITS'(DIVIDEND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DIVISOR_BITS-1:0];
        quo_nxt = {quo_r[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_BITS-1:0];
        quo_nxt = {quo_r[DIVIDEND_BITS-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_BITS'(1);
      if (step_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/sma_datapath.sv
module sma_datapath #(
  parameter int MAX_WINDOW  = sma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sma_pkg::ctrl_cmd_t                  cmd,
  output sma_pkg::ctrl_sts_t                  sts,
  input  logic                                in_cmd,
  input  logic [SAMPLE_BITS-1:0]              in_sample,
  input  logic                                cfg_we,
  input  logic [sma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sma_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [SAMPLE_BITS-1:0]              out_average,
  output logic                                out_window_full,
  output logic [sma_pkg::FILL_BITS-1:0]       out_fill_count
);

  localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_BITS = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CMP_BITS  = (CNT_BITS > sma_pkg::WINDOW_BITS) ? CNT_BITS
                                                               : sma_pkg::WINDOW_BITS;

  // configuration
  logic [sma_pkg::WINDOW_BITS-1:0] win_size_r, win_size_nxt;
  logic                            kind_r, kind_nxt;
  logic                            cfg_clear;

  // window state
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [CNT_BITS-1:0]        held_r, held_nxt;
  logic [SLOT_BITS-1:0]       slot_r, slot_nxt;
  logic                       evict_r, evict_nxt;

  // captured input beat
  logic                   cmd_r;
  logic [SAMPLE_BITS-1:0] sample_r;

  // sample ring
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]          avg_r;
  logic                            full_r;
  logic [sma_pkg::FILL_BITS-1:0]   fill_r;

  logic [CNT_BITS-1:0]        win_eff;
  logic [CNT_BITS:0]          slot_ext;
  logic [CNT_BITS:0]          held_ext;
  logic [CNT_BITS:0]          old_ext;
  logic [SLOT_BITS-1:0]       old_addr;
  logic signed [SUM_BITS-1:0] new_ext;
  logic signed [SUM_BITS-1:0] old_val;
  logic [SUM_BITS-1:0]        sum_mag;
  logic                       div_done;
  logic [SUM_BITS-1:0]        quotient;
  logic [SAMPLE_BITS-1:0]     q_low;
  logic [SAMPLE_BITS-1:0]     avg_val;

  // window size of zero acts as one, above the ring depth as the depth
  always_comb begin
    if (win_size_r == '0) begin
      win_eff = CNT_BITS'(1);
    end else if (CMP_BITS'(win_size_r) > CMP_BITS'(MAX_WINDOW)) begin
      win_eff = CNT_BITS'(MAX_WINDOW);
    end else begin
      win_eff = CNT_BITS'(win_size_r);
    end
  end

  // oldest slot: write slot minus fill, modulo depth
  assign slot_ext = (CNT_BITS + 1)'(slot_r);
  assign held_ext = {1'b0, held_r};
  assign old_ext  = (slot_ext >= held_ext) ? (slot_ext - held_ext)
                                           : (slot_ext + (CNT_BITS + 1)'(MAX_WINDOW) - held_ext);
  assign old_addr = old_ext[SLOT_BITS-1:0];

  assign new_ext = SUM_BITS'($signed(sample_r));
  assign old_val = evict_r ? SUM_BITS'($signed(rd_data_r)) : '0;

  assign cfg_clear = cfg_we && (cfg_index == sma_pkg::REG_WINDOW_SIZE);

  always_comb begin
    win_size_nxt = win_size_r;
    kind_nxt     = kind_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sma_pkg::REG_WINDOW_SIZE: win_size_nxt = cfg_data[sma_pkg::WINDOW_BITS-1:0];
        sma_pkg::REG_MEAN_KIND:   kind_nxt     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    slot_nxt  = slot_r;
    evict_nxt = evict_r;
    priority if (cfg_clear || cmd.clear_win) begin
      sum_nxt   = '0;
      held_nxt  = '0;
      slot_nxt  = '0;
      evict_nxt = 1'b0;
    end else if (cmd.rd_old) begin
      evict_nxt = (held_r == win_eff);
    end else if (cmd.update) begin
      sum_nxt  = sum_r - old_val + new_ext;
      held_nxt = evict_r ? held_r : held_r + CNT_BITS'(1);
      slot_nxt = (slot_r == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r  <= sma_pkg::WINDOW_RESET;
      kind_r      <= sma_pkg::KIND_SIMPLE;
      sum_r       <= '0;
      held_r      <= '0;
      slot_r      <= '0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_size_r  <= win_size_nxt;
      kind_r      <= kind_nxt;
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      slot_r      <= slot_nxt;
      evict_r     <= evict_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_cmd;
      sample_r <= in_sample;
    end
  end

  // ring: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_old) begin
      rd_data_r <= ring_mem[old_addr];
    end
    if (cmd.update) begin
      ring_mem[slot_r] <= sample_r;
    end
  end

  // mean: divide the magnitude, restore the sign; a clear or a non-simple kind gives zero
  assign sum_mag = sum_r[SUM_BITS-1] ? (~sum_r + SUM_BITS'(1)) : sum_r;

  sma_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_mag),
    .divisor  (held_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_low   = quotient[SAMPLE_BITS-1:0];
  assign avg_val = ((cmd_r == sma_pkg::CMD_CLEAR) || (kind_r != sma_pkg::KIND_SIMPLE)) ? '0
                 : (sum_r[SUM_BITS-1] ? (~q_low + SAMPLE_BITS'(1)) : q_low);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      avg_r  <= avg_val;
      full_r <= evict_r;
      fill_r <= sma_pkg::FILL_BITS'(held_r);
    end
  end

  assign sts.is_clear = (cmd_r == sma_pkg::CMD_CLEAR);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_average     = avg_r;
  assign out_window_full = full_r;
  assign out_fill_count  = fill_r;

endmodule

// File: sv/sma_ctrl.sv
module sma_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sma_pkg::ctrl_sts_t sts,
  output sma_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_START  = 3'd3;
  localparam logic [2:0] ST_DIVIDE = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.is_clear) begin
          cmd.clear_win = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.rd_old = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: test/sma_avg_checker.sv
module sma_avg_checker #(
  parameter int MAX_WINDOW  = sma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sma_in_if                                  in_mon,
  sma_out_if                                 out_mon,
  input  logic                               cfg_we,
  input  logic [sma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sma_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 err_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 evictions
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  average;
    logic                           window_full;
    logic [sma_pkg::FILL_BITS-1:0]  fill_count;
  } avg_result_t;

  logic signed [SAMPLE_BITS-1:0]   held_samples [MAX_WINDOW];
  longint                          run_sum;
  int                              n_held;
  int                              slot;
  logic [sma_pkg::WINDOW_BITS-1:0] size_reg;
  logic                            kind_reg;
  avg_result_t                     expected_q [$];

  function automatic void empty_window();
    run_sum = 0;
    n_held  = 0;
    slot    = 0;
  endfunction

  // size zero behaves as one, oversize as the ring depth
  function automatic int span();
    if (size_reg == '0) return 1;
    if (int'(size_reg) > MAX_WINDOW) return MAX_WINDOW;
    return int'(size_reg);
  endfunction

  function automatic avg_result_t advance_window(input logic c,
                                                 input logic signed [SAMPLE_BITS-1:0] s);
    avg_result_t r;
    int          oldest;
    r = '0;
    if (c == sma_pkg::CMD_CLEAR) begin
      empty_window();
      return r;
    end
    if (n_held >= span()) begin
      oldest = (slot + MAX_WINDOW - n_held) % MAX_WINDOW;
      run_sum -= held_samples[oldest];
      n_held--;
      r.window_full = 1'b1;
    end
    held_samples[slot] = s;
    run_sum += s;
    n_held++;
    slot = (slot + 1) % MAX_WINDOW;
    if (kind_reg == sma_pkg::KIND_SIMPLE) r.average = SAMPLE_BITS'(run_sum / n_held);
    r.fill_count = sma_pkg::FILL_BITS'(n_held);
    return r;
  endfunction

  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    if (!rst_n) begin
      empty_window();
      size_reg = sma_pkg::WINDOW_RESET;
      kind_reg = sma_pkg::KIND_SIMPLE;
      expected_q.delete();
    end else begin
      // results first: a beat accepted now cannot produce its result this edge
      if (out_mon.valid && out_mon.ready) begin
        got.average     = out_mon.average;
        got.window_full = out_mon.window_full;
        got.fill_count  = out_mon.fill_count;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got avg %0d full %0b fill %0d",
                   $time, got.average, got.window_full, got.fill_count);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.window_full) evictions++;
          if (got.average !== want.average || got.window_full !== want.window_full ||
              got.fill_count !== want.fill_count) begin
            $display("%0t: mismatch, expected avg %0d full %0b fill %0d,",
                     $time, want.average, want.window_full, want.fill_count);
            $display("%0t:   got avg %0d full %0b fill %0d",
                     $time, got.average, got.window_full, got.fill_count);
            err_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(advance_window(in_mon.cmd, in_mon.sample));
      if (cfg_we) begin
        if (cfg_index == sma_pkg::REG_WINDOW_SIZE) begin
          size_reg = cfg_data[sma_pkg::WINDOW_BITS-1:0];
          empty_window();
        end else if (cfg_index == sma_pkg::REG_MEAN_KIND) begin
          kind_reg = cfg_data[0];
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: test/tb_moving_average_window.sv
module tb_moving_average_window;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS  = sma_pkg::DEF_SAMPLE_BITS;
  localparam int N_ITEMS      = 1450;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 64;   // idle stretch after the last result is checked
  localparam int SMAX         = 32767;
  localparam int SMIN         = -32768;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [sma_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [sma_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  int err_count, pending, checked, evictions;
  int n_appends, n_clears, n_writes, n_holds;
  bit quiet_phase;   // no random gaps on either side while set
  bit hold_req;      // asks the receiver for one long hold-off
  int sample_style;

  sma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  sma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  moving_average_window u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watches both channels and the register port, predicts and compares
  sma_avg_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending),
    .checked   (checked),
    .evictions (evictions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sample flavours: full range, pinned near either rail, small, rail to rail
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case (sample_style)
      0:       return SAMPLE_BITS'($urandom);
      1:       return SAMPLE_BITS'(SMAX - int'($urandom_range(0, 15)));
      2:       return SAMPLE_BITS'(SMIN + int'($urandom_range(0, 15)));
      3:       return SAMPLE_BITS'(int'($urandom_range(0, 40)) - 20);
      default: return ($urandom_range(0, 1) != 0) ? SAMPLE_BITS'(SMAX) : SAMPLE_BITS'(SMIN);
    endcase
  endfunction

  // offer one beat and hold it until taken; valid stays high for a
  // back-to-back beat so it is never dropped and raised in one step
  task automatic send_beat(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == sma_pkg::CMD_CLEAR) n_clears++;
    else n_appends++;
  endtask

  // stop offering, wait for every outstanding result, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sma_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [sma_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // only bit 0 of the kind register counts, so the upper bits carry noise
  task automatic write_kind(input logic kind);
    write_reg(sma_pkg::REG_MEAN_KIND, {(sma_pkg::CFG_DATA_BITS-1)'($urandom), kind});
  endtask

  // receiver: random ready pattern, plus a long hold-off on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("timeout: %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int                              phase;
    int                              phase_len;
    logic [sma_pkg::WINDOW_BITS-1:0] win;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= sma_pkg::REG_WINDOW_SIZE;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= sma_pkg::CMD_APPEND;
    in_ch.sample <= '0;
    sample_style = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 8: clear on an empty window, then both rails and around zero
    send_beat(sma_pkg::CMD_CLEAR, SAMPLE_BITS'(SMAX));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMAX));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMIN));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(-1));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(1));
    send_beat(sma_pkg::CMD_APPEND, '0);
    send_beat(sma_pkg::CMD_CLEAR, SAMPLE_BITS'(-1));

    // size zero acts as one: every append after the first evicts
    settle();
    write_reg(sma_pkg::REG_WINDOW_SIZE, '0);
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMIN));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMAX));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(5));

    // oversize acts as the full ring, with the unsupported mean kind
    settle();
    write_reg(sma_pkg::REG_WINDOW_SIZE, '1);
    write_kind(1'b1);
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(-7));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(3));
    send_beat(sma_pkg::CMD_CLEAR, '0);
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(100));

    // window of 2: negative means truncate toward zero
    settle();
    write_reg(sma_pkg::REG_WINDOW_SIZE, sma_pkg::WINDOW_BITS'(2));
    write_kind(1'b0);
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMIN));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMIN + 1));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(-1));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(-2));
    send_beat(sma_pkg::CMD_APPEND, SAMPLE_BITS'(SMAX));

    // random phases: new settings, then mostly appends with the odd clear
    phase = 0;
    while (n_appends + n_clears < N_ITEMS) begin
      settle();
      if (phase == 0 || $urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 9))
          0:       win = '0;
          1:       win = sma_pkg::WINDOW_BITS'(64);
          2:       win = sma_pkg::WINDOW_BITS'($urandom_range(65, 127));
          3:       win = sma_pkg::WINDOW_BITS'(1);
          4, 5:    win = sma_pkg::WINDOW_BITS'($urandom_range(17, 64));
          default: win = sma_pkg::WINDOW_BITS'($urandom_range(2, 16));
        endcase
        write_reg(sma_pkg::REG_WINDOW_SIZE, win);
      end
      if ($urandom_range(0, 1) != 0) write_kind($urandom_range(0, 99) < 15);

      quiet_phase  = ($urandom_range(0, 4) == 0);
      sample_style = $urandom_range(0, 4);
      phase_len    = $urandom_range(20, 160);
      // the receiver stalls while the sender keeps pushing beats
      if (!hold_req && (phase == 1 || $urandom_range(0, 7) == 0)) hold_req = 1'b1;

      for (int i = 0; i < phase_len && n_appends + n_clears < N_ITEMS; i++) begin
        if ($urandom_range(0, 19) == 0) sample_style = $urandom_range(0, 4);
        if ($urandom_range(0, 99) < 4) send_beat(sma_pkg::CMD_CLEAR, SAMPLE_BITS'($urandom));
        else send_beat(sma_pkg::CMD_APPEND, pick_sample());
        // the sender now and then waits for the block to run dry mid-phase
        if ($urandom_range(0, 199) == 0) settle();
      end
      phase++;
    end

    quiet_phase = 1'b0;
    settle();

    $display("run summary: %0d appends and %0d clears over %0d register writes, %0d hold-offs",
             n_appends, n_clears, n_writes, n_holds);
    $display("run summary: %0d results checked, %0d of them evicting the oldest sample",
             checked, evictions);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sma_pkg.sv
sv/sma_chan_if.sv
sv/sma_div.sv
sv/sma_datapath.sv
sv/sma_ctrl.sv
sv/moving_average_window.sv
test/sma_avg_checker.sv
test/tb_moving_average_window.sv
